FILE: rtl/nusi_pkg.sv
// ----------------------------------------------------------------------------
// nusi_pkg - shared definitions for the nearest upsample source index block
// Widths, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package nusi_pkg;

    localparam int NUM_AXES  = 4;
    localparam int IDX_W     = 32;
    localparam int EXT_W     = 16;
    localparam int SCALE_W   = 16;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [SCALE_W-1:0] SCALE_ONE    = 16'd256;
    localparam logic [CFG_W-1:0]   SCALES_RESET = 64'h0100_0100_0100_0100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OUT_EXT_A0  = 3'd0,
        REG_OUT_EXT_A1  = 3'd1,
        REG_OUT_EXT_A2  = 3'd2,
        REG_OUT_EXT_A3  = 3'd3,
        REG_IN_EXT_A1   = 3'd4,
        REG_IN_EXT_A2   = 3'd5,
        REG_IN_EXT_A3   = 3'd6,
        REG_AXIS_SCALES = 3'd7
    } t_reg_idx;

endpackage

`default_nettype wire

FILE: rtl/nusi_div_cell.sv
// ----------------------------------------------------------------------------
// nusi_div_cell - one restoring division step
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits and records one quotient bit; all state is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module nusi_div_cell #(
    parameter int RW = 32,
    parameter int QB = 16,
    parameter int PW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [RW-1:0] i_rem,
    input  wire logic [QB-1:0] i_dvd,
    input  wire logic [QB-1:0] i_quo,
    input  wire logic [RW-1:0] i_div,
    input  wire logic [PW-1:0] i_pay,
    output logic               o_valid,
    output logic [RW-1:0]      o_rem,
    output logic [QB-1:0]      o_dvd,
    output logic [QB-1:0]      o_quo,
    output logic [PW-1:0]      o_pay
);

    logic            r_valid;
    logic [RW-1:0]   r_rem;
    logic [QB-1:0]   r_dvd;
    logic [QB-1:0]   r_quo;
    logic [PW-1:0]   r_pay;

    logic [RW:0]     w_trial;
    logic [RW:0]     w_diff;
    logic            w_fit;
    logic [RW-1:0]   n_rem;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        w_trial = {i_rem, i_dvd[QB-1]};
        w_diff  = w_trial - {1'b0, i_div};
        w_fit   = (w_trial >= {1'b0, i_div});
        n_rem   = w_fit ? w_diff[RW-1:0] : w_trial[RW-1:0];
    end

    // valid bit of the beat in this cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // advance remainder, dividend and quotient
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_dvd <= {i_dvd[QB-2:0], 1'b0};
            r_quo <= {i_quo[QB-2:0], w_fit};
            r_pay <= i_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_dvd   = r_dvd;
    assign o_quo   = r_quo;
    assign o_pay   = r_pay;

endmodule

`default_nettype wire

FILE: rtl/nusi_div_chain.sv
// ----------------------------------------------------------------------------
// nusi_div_chain - row of division cells
// Produces one quotient bit per cell, most significant first; the remainder
// comes out with the quotient after QB cells. Payload travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module nusi_div_chain #(
    parameter int RW = nusi_pkg::IDX_W,
    parameter int QB = nusi_pkg::EXT_W,
    parameter int PW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [RW-1:0] i_rem,
    input  wire logic [QB-1:0] i_dvd,
    input  wire logic [RW-1:0] i_div,
    input  wire logic [PW-1:0] i_pay,
    output logic               o_valid,
    output logic [RW-1:0]      o_rem,
    output logic [QB-1:0]      o_quo,
    output logic [PW-1:0]      o_pay
);

    logic          w_valid [QB+1];
    logic [RW-1:0] w_rem   [QB+1];
    logic [QB-1:0] w_dvd   [QB+1];
    logic [QB-1:0] w_quo   [QB+1];
    logic [PW-1:0] w_pay   [QB+1];

    assign w_valid[0] = i_valid;
    assign w_rem[0]   = i_rem;
    assign w_dvd[0]   = i_dvd;
    assign w_quo[0]   = '0;
    assign w_pay[0]   = i_pay;

    // one cell per quotient bit
    for (genvar g = 0; g < QB; g++) begin : g_cell
        nusi_div_cell #(
            .RW (RW),
            .QB (QB),
            .PW (PW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_valid[g]),
            .i_rem   (w_rem[g]),
            .i_dvd   (w_dvd[g]),
            .i_quo   (w_quo[g]),
            .i_div   (i_div),
            .i_pay   (w_pay[g]),
            .o_valid (w_valid[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_dvd   (w_dvd[g+1]),
            .o_quo   (w_quo[g+1]),
            .o_pay   (w_pay[g+1])
        );
    end

    assign o_valid = w_valid[QB];
    assign o_rem   = w_rem[QB];
    assign o_quo   = w_quo[QB];
    assign o_pay   = w_pay[QB];

endmodule

`default_nettype wire

FILE: rtl/nearest_upsample_source_index.sv
// ----------------------------------------------------------------------------
// nearest_upsample_source_index - source index for nearest upsampling
// Splits a linear output index into four coordinates, scales each one down,
// clamps the inner ones and recombines them with the input strides.
// ----------------------------------------------------------------------------
// Pipeline: input register, 32 + 16 + 16 cells of coordinate
//   division, 32 cells of scale division, multiply stage, sum stage.
// Throughput: one beat per cycle; the whole cell row stalls together when
//   the output beat is not taken.
// Reset: synchronous, active low; clears all valid bits and restores the
//   register defaults. Stride products follow a write through their registers.
`default_nettype none

module nearest_upsample_source_index #(
    parameter int AXES = nusi_pkg::NUM_AXES
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_we,
    input  wire logic [nusi_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [nusi_pkg::CFG_W-1:0]     i_cfg_data,
    // input stream
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [31:0]                    i_s_tdata,  // [31:0] out_index
    // result stream
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [31:0]                         o_m_tdata,  // [31:0] src_index
    output logic                                o_m_tuser   // [0] out_of_range
);

    localparam int EW   = nusi_pkg::EXT_W;
    localparam int IW   = nusi_pkg::IDX_W;
    localparam int LEAD = nusi_pkg::NUM_AXES - AXES;

    // configuration registers
    logic [EW-1:0]              r_out_ext [4];
    logic [EW-1:0]              r_in_ext  [3];
    logic [nusi_pkg::CFG_W-1:0] r_scales;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_out_ext[k] <= EW'(1);
            for (int k = 0; k < 3; k++) r_in_ext[k]  <= EW'(1);
            r_scales <= nusi_pkg::SCALES_RESET;
        end else if (i_cfg_we) begin
            unique case (nusi_pkg::t_reg_idx'(i_cfg_idx))
                nusi_pkg::REG_OUT_EXT_A0:  r_out_ext[0] <= i_cfg_data[EW-1:0];
                nusi_pkg::REG_OUT_EXT_A1:  r_out_ext[1] <= i_cfg_data[EW-1:0];
                nusi_pkg::REG_OUT_EXT_A2:  r_out_ext[2] <= i_cfg_data[EW-1:0];
                nusi_pkg::REG_OUT_EXT_A3:  r_out_ext[3] <= i_cfg_data[EW-1:0];
                nusi_pkg::REG_IN_EXT_A1:   r_in_ext[0]  <= i_cfg_data[EW-1:0];
                nusi_pkg::REG_IN_EXT_A2:   r_in_ext[1]  <= i_cfg_data[EW-1:0];
                nusi_pkg::REG_IN_EXT_A3:   r_in_ext[2]  <= i_cfg_data[EW-1:0];
                nusi_pkg::REG_AXIS_SCALES: r_scales     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective extents and scales: zero extent is one, small scale is one,
    // leading unused axes are one
    logic [EW-1:0]               n_oe [4];
    logic [EW-1:0]               n_ie [4];
    logic [nusi_pkg::SCALE_W-1:0] n_sc [4];
    logic [EW-1:0]               r_oe [4];
    logic [EW-1:0]               r_ie [4];
    logic [nusi_pkg::SCALE_W-1:0] r_sc [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_oe[k] = (k < LEAD || r_out_ext[k] == '0) ? EW'(1) : r_out_ext[k];
            n_sc[k] = r_scales[(3-k)*16 +: 16];
            if (k < LEAD || n_sc[k] < nusi_pkg::SCALE_ONE) begin
                n_sc[k] = nusi_pkg::SCALE_ONE;
            end
        end
        n_ie[0] = EW'(1);
        for (int k = 1; k < 4; k++) begin
            n_ie[k] = (k < LEAD || r_in_ext[k-1] == '0) ? EW'(1) : r_in_ext[k-1];
        end
    end

    // stride products, one multiply per stage
    logic [31:0] r_os1;
    logic [47:0] r_os0;
    logic [63:0] r_total;
    logic [32:0] r_div0;
    logic [31:0] r_is1;
    logic [31:0] r_is0;
    logic [31:0] w_is0;

    assign w_is0 = r_is1 * {16'd0, r_ie[1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_oe[k] <= EW'(1);
                r_ie[k] <= EW'(1);
                r_sc[k] <= nusi_pkg::SCALE_ONE;
            end
            r_os1   <= 32'd1;
            r_os0   <= 48'd1;
            r_total <= 64'd1;
            r_div0  <= 33'd1;
            r_is1   <= 32'd1;
            r_is0   <= 32'd1;
        end else begin
            r_oe    <= n_oe;
            r_ie    <= n_ie;
            r_sc    <= n_sc;
            r_os1   <= {16'd0, r_oe[2]} * {16'd0, r_oe[3]};
            r_is1   <= {16'd0, r_ie[2]} * {16'd0, r_ie[3]};
            r_os0   <= {16'd0, r_os1} * {32'd0, r_oe[1]};
            r_is0   <= w_is0;
            r_total <= {16'd0, r_os0} * {48'd0, r_oe[0]};
            // clip the outer stride: any index below 2^32 gives quotient zero
            r_div0  <= (r_os0[47:32] != '0) ? {1'b1, 32'd0} : {1'b0, r_os0[31:0]};
        end
    end

    // whole row advances when the output register is free or drained
    logic w_adv;
    assign w_adv      = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_adv;

    // input register and range check
    logic          r_v0;
    logic [IW-1:0] r_idx;
    logic          r_oor0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_adv) begin
            r_v0 <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_idx  <= i_s_tdata;
            r_oor0 <= ({32'd0, i_s_tdata} >= r_total);
        end
    end

    // coordinate of axis 0
    logic          w_va;
    logic [32:0]   w_rema;
    logic [31:0]   w_c0;
    logic          w_oora;

    nusi_div_chain #(.RW(33), .QB(32), .PW(1)) u_div_a0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_v0),
        .i_rem   (33'd0),
        .i_dvd   (r_idx),
        .i_div   (r_div0),
        .i_pay   (r_oor0),
        .o_valid (w_va),
        .o_rem   (w_rema),
        .o_quo   (w_c0),
        .o_pay   (w_oora)
    );

    // coordinate of axis 1
    logic          w_vb;
    logic [31:0]   w_remb;
    logic [15:0]   w_c1;
    logic [32:0]   w_payb;

    nusi_div_chain #(.RW(32), .QB(16), .PW(33)) u_div_a1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_va),
        .i_rem   ({16'd0, w_rema[31:16]}),
        .i_dvd   (w_rema[15:0]),
        .i_div   (r_os1),
        .i_pay   ({w_oora, w_c0}),
        .o_valid (w_vb),
        .o_rem   (w_remb),
        .o_quo   (w_c1),
        .o_pay   (w_payb)
    );

    // coordinate of axis 2, remainder is axis 3
    logic          w_vc;
    logic [31:0]   w_remc;
    logic [15:0]   w_c2;
    logic [48:0]   w_payc;

    nusi_div_chain #(.RW(32), .QB(16), .PW(49)) u_div_a2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_vb),
        .i_rem   ({16'd0, w_remb[31:16]}),
        .i_dvd   (w_remb[15:0]),
        .i_div   ({16'd0, r_oe[3]}),
        .i_pay   ({w_payb, w_c1}),
        .o_valid (w_vc),
        .o_rem   (w_remc),
        .o_quo   (w_c2),
        .o_pay   (w_payc)
    );

    // scale every coordinate down: floor(c * 256 / scale), four lanes
    logic [31:0] w_coord [4];
    logic        w_vm    [4];
    logic [31:0] w_m     [4];
    logic        w_oorm  [4];

    assign w_coord[0] = w_payc[47:16];
    assign w_coord[1] = {16'd0, w_payc[15:0]};
    assign w_coord[2] = {16'd0, w_c2};
    assign w_coord[3] = {16'd0, w_remc[15:0]};

    for (genvar g = 0; g < 4; g++) begin : g_map
        nusi_div_chain #(.RW(16), .QB(32), .PW(1)) u_div_map (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_vc),
            .i_rem   ({8'd0, w_coord[g][31:24]}),
            .i_dvd   ({w_coord[g][23:0], 8'd0}),
            .i_div   (r_sc[g]),
            .i_pay   (w_payc[48]),
            .o_valid (w_vm[g]),
            .o_rem   (),
            .o_quo   (w_m[g]),
            .o_pay   (w_oorm[g])
        );
    end

    // clamp inner axes and weight by input strides
    logic [15:0] w_lim [4];
    logic [15:0] w_mc  [4];
    logic [31:0] w_p0;
    logic [31:0] w_p1;
    logic [31:0] w_p2;

    always_comb begin
        w_lim[0] = '0;
        w_mc[0]  = '0;
        for (int k = 1; k < 4; k++) begin
            w_lim[k] = r_ie[k] - 16'd1;
            w_mc[k]  = (w_m[k] > {16'd0, w_lim[k]}) ? w_lim[k] : w_m[k][15:0];
        end
    end

    assign w_p0 = w_m[0] * r_is0;
    assign w_p1 = {16'd0, w_mc[1]} * r_is1;
    assign w_p2 = {16'd0, w_mc[2]} * {16'd0, r_ie[3]};

    logic        r_v5;
    logic        r_oor5;
    logic [31:0] r_p [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_adv) begin
            r_v5 <= w_vm[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_oor5 <= w_oorm[0];
            r_p[0] <= w_p0;
            r_p[1] <= w_p1;
            r_p[2] <= w_p2;
            r_p[3] <= {16'd0, w_mc[3]};
        end
    end

    // sum into the output register; zero the index when out of range
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic        r_out_oor;
    logic [31:0] n_sum;

    assign n_sum = r_p[0] + r_p[1] + r_p[2] + r_p[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= r_oor5 ? 32'd0 : n_sum;
            r_out_oor  <= r_oor5;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_oor;

    // out-of-range beats carry a zero index
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == 32'd0))
        else $error("out-of-range beat with nonzero index");

    // a stalled result keeps its content
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser)))
        else $error("stalled result changed");

    // input side is held off exactly while a result waits
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_tready == (!o_m_tvalid || i_m_tready)))
        else $error("ready does not follow output stall");

    // reset leaves no result pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
